// ===== rtl/core/stt_pkg.sv =====
// ----------------------------------------------------------------------------
// stt_pkg: shared definitions for segment table translation
// Field widths, operation and status codes, register map and the table entry
// layout used by the translation core.
// ----------------------------------------------------------------------------
`default_nettype none

package stt_pkg;

  // Default sizing
  localparam int MAX_SEGMENTS_DEF    = 8;
  localparam int WRITE_FLAG_MASK_DEF = 2;

  // Field widths
  localparam int FLAGS_W  = 4;
  localparam int VADDR_W  = 32;
  localparam int ENTRY_W  = 3;
  localparam int CFG_W    = 4;
  localparam int APB_AW   = 3;
  localparam int APB_DW   = 32;

  // Register map (word index = paddr[2])
  localparam logic REG_SEGMENTS_IN_USE = 1'b0;
  localparam logic [CFG_W-1:0] SEGMENTS_IN_USE_RST = 4'd8;

  // Operation codes
  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_FETCH = 2'd1;
  localparam logic [1:0] OP_SET   = 2'd2;

  // Status codes
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_BAD_INDEX = 2'd1;
  localparam logic [1:0] STATUS_MISS      = 2'd2;

  // One table entry
  typedef struct packed {
    logic [FLAGS_W-1:0] flags;
    logic [VADDR_W-1:0] start;
    logic [VADDR_W-1:0] length;
  } seg_entry_t;

endpackage

`default_nettype wire

// ===== rtl/core/segment_table_translate.sv =====
// Timing: a load answers in the cycle after acceptance. A fetch or set reads the live
// entries in order from entry 0 into a register and compares each, one table entry per
// cycle, answering at the first hit or after the last live entry on a miss; with a live
// segment count of zero it answers a miss in the cycle after acceptance. Throughput: one
// transaction at a time; the next is accepted at the edge that ends the result cycle.
// Reset: synchronous, active low; clears valid bits, count to 8, idle. Results cannot stall.
// ----------------------------------------------------------------------------
// segment_table_translate: segment table address translation
// Holds a small segment table, loads entries and translates fetch and set
// accesses by a first-match scan over the live entries.
// ----------------------------------------------------------------------------
`default_nettype none

module segment_table_translate
  import stt_pkg::*;
#(
  parameter int MAX_SEGMENTS    = MAX_SEGMENTS_DEF,
  parameter int WRITE_FLAG_MASK = WRITE_FLAG_MASK_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  // command channel
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [1:0]          in_op,
  input  wire logic [ENTRY_W-1:0]  in_entry_index,
  input  wire logic [FLAGS_W-1:0]  in_entry_flags,
  input  wire logic [VADDR_W-1:0]  in_entry_start,
  input  wire logic [VADDR_W-1:0]  in_entry_length,
  input  wire logic [VADDR_W-1:0]  in_access_addr,
  input  wire logic [FLAGS_W-1:0]  in_access_kind,
  // result channel
  output logic                     out_valid,
  output logic [1:0]               out_status,
  output logic [ENTRY_W-1:0]       out_hit_entry,
  output logic [VADDR_W-1:0]       out_hit_offset,
  // configuration port
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [APB_AW-1:0]   paddr,
  input  wire logic [APB_DW-1:0]   pwdata,
  output logic [APB_DW-1:0]        prdata,
  output logic                     pready
);

  localparam int IDX_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

  // --------------------------------------------------------------------------
  // Configuration register
  // --------------------------------------------------------------------------
  logic [CFG_W-1:0] seg_in_use_r;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_SEGMENTS_IN_USE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_in_use_r <= SEGMENTS_IN_USE_RST;
    end else if (cfg_wr) begin
      seg_in_use_r <= pwdata[CFG_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_SEGMENTS_IN_USE) begin
      prdata = APB_DW'(seg_in_use_r);
    end
  end

  // Clamp the live count to the table size
  logic [CNT_W-1:0] live_cnt;

  always_comb begin
    if (32'(seg_in_use_r) > 32'(MAX_SEGMENTS)) begin
      live_cnt = CNT_W'(MAX_SEGMENTS);
    end else begin
      live_cnt = CNT_W'(seg_in_use_r);
    end
  end

  // --------------------------------------------------------------------------
  // Segment table memory and per-entry valid bits
  // --------------------------------------------------------------------------
  seg_entry_t              mem [MAX_SEGMENTS];
  logic [MAX_SEGMENTS-1:0] valid_r;
  seg_entry_t              rd_data_r;
  logic                    rd_live_r;

  logic                    mem_we;
  logic [IDX_W-1:0]        mem_waddr;
  seg_entry_t              mem_wdata;
  logic                    mem_re;
  logic [IDX_W-1:0]        mem_raddr;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_raddr];
    end
  end

  // Unwritten entries read as empty (no flags) through the valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= '0;
      rd_live_r <= 1'b0;
    end else begin
      if (mem_we) begin
        valid_r[mem_waddr] <= 1'b1;
      end
      if (mem_re) begin
        rd_live_r <= valid_r[mem_raddr];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Shared compare unit: flag match and range check on the read entry
  // --------------------------------------------------------------------------
  logic [VADDR_W-1:0] addr_r;
  logic [FLAGS_W-1:0] need_r;
  logic [VADDR_W:0]   diff;
  logic               hit;

  assign diff = {1'b0, addr_r} - {1'b0, rd_data_r.start};
  assign hit  = rd_live_r && ((rd_data_r.flags & need_r) != '0) && !diff[VADDR_W] &&
                (diff[VADDR_W-1:0] < rd_data_r.length);

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   scan_idx_r, scan_idx_nxt;
  logic [CNT_W-1:0]   cmp_idx_r, cmp_idx_nxt;
  logic               cmp_vld_r, cmp_vld_nxt;
  logic [VADDR_W-1:0] addr_nxt;
  logic [FLAGS_W-1:0] need_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [1:0]         status_r, status_nxt;
  logic [ENTRY_W-1:0] hit_entry_r, hit_entry_nxt;
  logic [VADDR_W-1:0] hit_offset_r, hit_offset_nxt;
  logic               accept;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  always_comb begin
    state_nxt      = state_r;
    scan_idx_nxt   = scan_idx_r;
    cmp_idx_nxt    = cmp_idx_r;
    cmp_vld_nxt    = 1'b0;
    addr_nxt       = addr_r;
    need_nxt       = need_r;
    out_valid_nxt  = 1'b0;
    status_nxt     = status_r;
    hit_entry_nxt  = hit_entry_r;
    hit_offset_nxt = hit_offset_r;
    mem_we         = 1'b0;
    mem_waddr      = IDX_W'(in_entry_index);
    mem_wdata      = '{flags: in_entry_flags, start: in_entry_start, length: in_entry_length};
    mem_re         = 1'b0;
    mem_raddr      = scan_idx_r[IDX_W-1:0];

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          addr_nxt       = in_access_addr;
          need_nxt       = (in_op == OP_SET) ? FLAGS_W'(WRITE_FLAG_MASK) : in_access_kind;
          hit_entry_nxt  = '0;
          hit_offset_nxt = '0;
          unique case (in_op) inside
            OP_LOAD: begin
              // Write the entry, or refuse an index past the live count
              out_valid_nxt = 1'b1;
              if (32'(in_entry_index) < 32'(live_cnt)) begin
                mem_we        = 1'b1;
                status_nxt    = STATUS_OK;
                hit_entry_nxt = in_entry_index;
              end else begin
                status_nxt    = STATUS_BAD_INDEX;
              end
            end
            OP_FETCH, OP_SET: begin
              if (live_cnt == '0) begin
                out_valid_nxt = 1'b1;
                status_nxt    = STATUS_MISS;
              end else begin
                scan_idx_nxt  = '0;
                state_nxt     = ST_SCAN;
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
              status_nxt    = STATUS_MISS;
            end
          endcase
        end
      end

      ST_SCAN: begin
        // Issue the next read while entries remain
        if (scan_idx_r < live_cnt) begin
          mem_re       = 1'b1;
          cmp_vld_nxt  = 1'b1;
          cmp_idx_nxt  = scan_idx_r;
          scan_idx_nxt = scan_idx_r + 1'b1;
        end
        // Compare the entry read in the previous cycle
        if (cmp_vld_r) begin
          if (hit) begin
            out_valid_nxt  = 1'b1;
            status_nxt     = STATUS_OK;
            hit_entry_nxt  = ENTRY_W'(cmp_idx_r);
            hit_offset_nxt = diff[VADDR_W-1:0];
            cmp_vld_nxt    = 1'b0;
            state_nxt      = ST_IDLE;
          end else if (32'(cmp_idx_r) + 32'd1 >= 32'(live_cnt)) begin
            out_valid_nxt  = 1'b1;
            status_nxt     = STATUS_MISS;
            cmp_vld_nxt    = 1'b0;
            state_nxt      = ST_IDLE;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
    scan_idx_r   <= scan_idx_nxt;
    cmp_idx_r    <= cmp_idx_nxt;
    addr_r       <= addr_nxt;
    need_r       <= need_nxt;
    status_r     <= status_nxt;
    hit_entry_r  <= hit_entry_nxt;
    hit_offset_r <= hit_offset_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_status     = status_r;
  assign out_hit_entry  = hit_entry_r;
  assign out_hit_offset = hit_offset_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_result_follows_work : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start || busy))
    else $error("result strobe without a transaction in progress");

  a_error_clears_fields : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != STATUS_OK)) |-> (out_hit_entry == '0 && out_hit_offset == '0))
    else $error("error result carries entry or offset");

  a_bad_load_refused : assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_op == OP_LOAD && (32'(in_entry_index) >= 32'(live_cnt)))
    |=> (out_valid && out_status == STATUS_BAD_INDEX))
    else $error("out-of-range load not refused");

  a_scan_in_bounds : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (scan_idx_r <= live_cnt && (!cmp_vld_r || cmp_idx_r < live_cnt)))
    else $error("scan index past live count");

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: self-checking bench for segment_table_translate
// Drives load, fetch and set transactions through the start/busy channel and
// rewrites the segment count over the APB port between phases. An in-bench
// translation model predicts results not given by checked rows; results are
// compared field by field in arrival order. A short scripted sequence covers
// reset state, range ends, refused loads and count extremes, then random
// traffic aimed at the loaded segments runs under three sender idle patterns.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  import stt_pkg::*;

  localparam logic [1:0]        OP_SPARE       = 2'd3;
  localparam logic [APB_AW-1:0] SEG_COUNT_ADDR = {REG_SEGMENTS_IN_USE, 2'b00};
  localparam int                CYCLE_LIMIT    = 300000;

  typedef struct packed {
    logic [1:0]         op;
    logic [ENTRY_W-1:0] index;
    logic [FLAGS_W-1:0] flags;
    logic [VADDR_W-1:0] base;
    logic [VADDR_W-1:0] size;
    logic [VADDR_W-1:0] addr;
    logic [FLAGS_W-1:0] need;
  } seg_cmd_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [ENTRY_W-1:0] entry;
    logic [VADDR_W-1:0] offset;
  } xlate_t;

  typedef enum logic [1:0] {ROW_ITEM, ROW_CHECKED, ROW_COUNT} row_kind_t;

  typedef struct packed {
    row_kind_t        kind;
    logic [CFG_W-1:0] count;
    seg_cmd_t         cmd;
    xlate_t           want;
  } script_row_t;

  localparam seg_cmd_t NO_CMD  = '0;
  localparam xlate_t   NO_WANT = '0;

  // Scripted opening: empty table, range ends, first match, count extremes
  localparam script_row_t SCRIPT [28] = '{
    '{ROW_CHECKED, 4'd0, '{OP_FETCH, 3'd0, 4'h0, 32'h0, 32'h0, 32'h0, 4'hF},
      '{STATUS_MISS, 3'd0, 32'h0}},
    '{ROW_CHECKED, 4'd0, '{OP_SET, 3'd0, 4'h0, 32'h0, 32'h0, 32'hFFFF_FFFF, 4'h0},
      '{STATUS_MISS, 3'd0, 32'h0}},
    '{ROW_CHECKED, 4'd0, '{OP_SPARE, 3'd7, 4'hF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 4'hF},
      '{STATUS_MISS, 3'd0, 32'h0}},
    '{ROW_CHECKED, 4'd0, '{OP_LOAD, 3'd0, 4'hF, 32'h0, 32'h10, 32'h0, 4'h0},
      '{STATUS_OK, 3'd0, 32'h0}},
    '{ROW_CHECKED, 4'd0, '{OP_LOAD, 3'd7, 4'h2, 32'hFFFF_FFF0, 32'h10, 32'h0, 4'h0},
      '{STATUS_OK, 3'd7, 32'h0}},
    '{ROW_CHECKED, 4'd0, '{OP_FETCH, 3'd0, 4'h0, 32'h0, 32'h0, 32'hF, 4'h1},
      '{STATUS_OK, 3'd0, 32'hF}},
    '{ROW_CHECKED, 4'd0, '{OP_FETCH, 3'd0, 4'h0, 32'h0, 32'h0, 32'h10, 4'hF},
      '{STATUS_MISS, 3'd0, 32'h0}},
    '{ROW_CHECKED, 4'd0, '{OP_FETCH, 3'd0, 4'h0, 32'h0, 32'h0, 32'hFFFF_FFFF, 4'h2},
      '{STATUS_OK, 3'd7, 32'hF}},
    '{ROW_CHECKED, 4'd0, '{OP_SET, 3'd0, 4'h0, 32'h0, 32'h0, 32'hFFFF_FFF0, 4'h0},
      '{STATUS_OK, 3'd7, 32'h0}},
    '{ROW_CHECKED, 4'd0, '{OP_FETCH, 3'd0, 4'h0, 32'h0, 32'h0, 32'hFFFF_FFF0, 4'h0},
      '{STATUS_MISS, 3'd0, 32'h0}},
    '{ROW_CHECKED, 4'd0, '{OP_LOAD, 3'd3, 4'h4, 32'h100, 32'h0, 32'h0, 4'h0},
      '{STATUS_OK, 3'd3, 32'h0}},
    '{ROW_CHECKED, 4'd0, '{OP_FETCH, 3'd0, 4'h0, 32'h0, 32'h0, 32'h100, 4'h4},
      '{STATUS_MISS, 3'd0, 32'h0}},
    '{ROW_ITEM, 4'd0, '{OP_LOAD, 3'd1, 4'h8, 32'h0, 32'hFFFF_FFFF, 32'h0, 4'h0}, NO_WANT},
    '{ROW_ITEM, 4'd0, '{OP_FETCH, 3'd0, 4'h0, 32'h0, 32'h0, 32'h5, 4'h8}, NO_WANT},
    '{ROW_ITEM, 4'd0, '{OP_FETCH, 3'd0, 4'h0, 32'h0, 32'h0, 32'h5, 4'h9}, NO_WANT},
    '{ROW_ITEM, 4'd0, '{OP_SET, 3'd0, 4'h0, 32'h0, 32'h0, 32'h5, 4'h0}, NO_WANT},
    '{ROW_ITEM, 4'd0, '{OP_LOAD, 3'd2, 4'h2, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 4'h0},
      NO_WANT},
    '{ROW_ITEM, 4'd0, '{OP_FETCH, 3'd0, 4'h0, 32'h0, 32'h0, 32'hFFFF_FFFF, 4'h2}, NO_WANT},
    '{ROW_COUNT, 4'd2, NO_CMD, NO_WANT},
    '{ROW_CHECKED, 4'd0, '{OP_LOAD, 3'd2, 4'hF, 32'h0, 32'h1, 32'h0, 4'h0},
      '{STATUS_BAD_INDEX, 3'd0, 32'h0}},
    '{ROW_CHECKED, 4'd0, '{OP_LOAD, 3'd7, 4'hF, 32'h0, 32'h1, 32'h0, 4'h0},
      '{STATUS_BAD_INDEX, 3'd0, 32'h0}},
    '{ROW_ITEM, 4'd0, '{OP_FETCH, 3'd0, 4'h0, 32'h0, 32'h0, 32'hFFFF_FFFF, 4'hF}, NO_WANT},
    '{ROW_COUNT, 4'd0, NO_CMD, NO_WANT},
    '{ROW_CHECKED, 4'd0, '{OP_FETCH, 3'd0, 4'h0, 32'h0, 32'h0, 32'h0, 4'hF},
      '{STATUS_MISS, 3'd0, 32'h0}},
    '{ROW_CHECKED, 4'd0, '{OP_LOAD, 3'd0, 4'hF, 32'h0, 32'h10, 32'h0, 4'h0},
      '{STATUS_BAD_INDEX, 3'd0, 32'h0}},
    '{ROW_COUNT, 4'd15, NO_CMD, NO_WANT},
    '{ROW_ITEM, 4'd0, '{OP_FETCH, 3'd0, 4'h0, 32'h0, 32'h0, 32'hFFFF_FFFF, 4'hF}, NO_WANT},
    '{ROW_CHECKED, 4'd0, '{OP_LOAD, 3'd7, 4'hF, 32'h0, 32'h0, 32'h0, 4'h0},
      '{STATUS_OK, 3'd7, 32'h0}}
  };

  logic                clk             = 1'b0;
  logic                rst_n           = 1'b0;
  logic                start           = 1'b0;
  logic                busy;
  logic [1:0]          in_op           = '0;
  logic [ENTRY_W-1:0]  in_entry_index  = '0;
  logic [FLAGS_W-1:0]  in_entry_flags  = '0;
  logic [VADDR_W-1:0]  in_entry_start  = '0;
  logic [VADDR_W-1:0]  in_entry_length = '0;
  logic [VADDR_W-1:0]  in_access_addr  = '0;
  logic [FLAGS_W-1:0]  in_access_kind  = '0;
  logic                out_valid;
  logic [1:0]          out_status;
  logic [ENTRY_W-1:0]  out_hit_entry;
  logic [VADDR_W-1:0]  out_hit_offset;
  logic                psel            = 1'b0;
  logic                penable         = 1'b0;
  logic                pwrite          = 1'b0;
  logic [APB_AW-1:0]   paddr           = '0;
  logic [APB_DW-1:0]   pwdata          = '0;
  logic [APB_DW-1:0]   prdata;
  logic                pready;

  // Shadow of the segment table and the count register
  logic [FLAGS_W-1:0]  tbl_flags [MAX_SEGMENTS_DEF] = '{default: '0};
  logic [VADDR_W-1:0]  tbl_base  [MAX_SEGMENTS_DEF] = '{default: '0};
  logic [VADDR_W-1:0]  tbl_size  [MAX_SEGMENTS_DEF] = '{default: '0};
  logic [CFG_W-1:0]    seg_count = SEGMENTS_IN_USE_RST;

  xlate_t              pending_xlates [$];
  xlate_t              oldest;
  int                  mismatches = 0;
  int                  gap_pct    = 0;
  int                  cycles     = 0;

  segment_table_translate uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_op           (in_op),
    .in_entry_index  (in_entry_index),
    .in_entry_flags  (in_entry_flags),
    .in_entry_start  (in_entry_start),
    .in_entry_length (in_entry_length),
    .in_access_addr  (in_access_addr),
    .in_access_kind  (in_access_kind),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_hit_entry   (out_hit_entry),
    .out_hit_offset  (out_hit_offset),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Bound the run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("segment_table_translate: mismatch");
      $finish;
    end
  end

  // Translate one transaction and update the shadow table on a load
  function automatic xlate_t translate(input seg_cmd_t c);
    xlate_t             r;
    int                 live;
    logic [FLAGS_W-1:0] need;
    logic [VADDR_W:0]   lim;
    r    = '{STATUS_MISS, '0, '0};
    live = (seg_count > MAX_SEGMENTS_DEF) ? MAX_SEGMENTS_DEF : int'(seg_count);
    if (c.op == OP_LOAD) begin
      if (c.index < live) begin
        tbl_flags[c.index] = c.flags;
        tbl_base[c.index]  = c.base;
        tbl_size[c.index]  = c.size;
        r.status = STATUS_OK;
        r.entry  = c.index;
      end else begin
        r.status = STATUS_BAD_INDEX;
      end
    end else if (c.op == OP_FETCH || c.op == OP_SET) begin
      need = (c.op == OP_FETCH) ? c.need : FLAGS_W'(WRITE_FLAG_MASK_DEF);
      // scan from the top so the lowest matching entry wins
      for (int i = live - 1; i >= 0; i--) begin
        lim = {1'b0, tbl_base[i]} + {1'b0, tbl_size[i]};
        if ((tbl_flags[i] & need) != '0 && c.addr >= tbl_base[i] && {1'b0, c.addr} < lim)
        begin
          r.status = STATUS_OK;
          r.entry  = ENTRY_W'(i);
          r.offset = c.addr - tbl_base[i];
        end
      end
    end
    return r;
  endfunction

  // Random transaction, mostly loads and accesses aimed at loaded segments
  function automatic seg_cmd_t random_cmd();
    seg_cmd_t         c;
    int               roll;
    int               live;
    int               j;
    logic [VADDR_W-1:0] off;
    logic [VADDR_W:0]   sum;
    c.op    = 2'($urandom_range(3));
    c.index = ENTRY_W'($urandom);
    c.flags = FLAGS_W'($urandom);
    c.base  = $urandom;
    c.size  = $urandom;
    c.addr  = $urandom;
    c.need  = FLAGS_W'($urandom);
    live = (seg_count > MAX_SEGMENTS_DEF) ? MAX_SEGMENTS_DEF : int'(seg_count);
    roll = $urandom_range(99);
    if (roll < 30) begin
      // load, mostly into a live slot, with a spread of segment sizes
      c.op = OP_LOAD;
      if (live > 0 && $urandom_range(3) != 0) c.index = ENTRY_W'($urandom_range(live - 1));
      case ($urandom_range(4))
        0: c.size = VADDR_W'($urandom_range(64));
        1: c.size = '1 - VADDR_W'($urandom_range(3));
        2: c.base = '1 - VADDR_W'($urandom_range(255));
        3: c.size = VADDR_W'($urandom_range(4096));
        default: ;
      endcase
    end else if (roll < 85) begin
      // access at, inside or just past one table entry
      c.op = (roll < 65) ? OP_FETCH : OP_SET;
      j = $urandom_range(MAX_SEGMENTS_DEF - 1);
      case ($urandom_range(3))
        0: off = '0;
        1: off = tbl_size[j] - 1'b1;
        2: off = tbl_size[j];
        default: off = (tbl_size[j] == '0) ? '0 : VADDR_W'($urandom % tbl_size[j]);
      endcase
      sum    = {1'b0, tbl_base[j]} + {1'b0, off};
      c.addr = sum[VADDR_W] ? '1 : sum[VADDR_W-1:0];
      if ($urandom_range(3) != 0) c.need = c.need | tbl_flags[j];
    end
    return c;
  endfunction

  // Present one transaction, hold it until accepted, queue its result
  task automatic issue(input seg_cmd_t c, input bit typed, input xlate_t want);
    xlate_t predicted;
    while ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start           <= 1'b1;
    in_op           <= c.op;
    in_entry_index  <= c.index;
    in_entry_flags  <= c.flags;
    in_entry_start  <= c.base;
    in_entry_length <= c.size;
    in_access_addr  <= c.addr;
    in_access_kind  <= c.need;
    @(posedge clk);
    while (busy) @(posedge clk);
    predicted = translate(c);
    pending_xlates.push_back(typed ? want : predicted);
  endtask

  // Drop start and wait until every result is back and the block is quiet
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending_xlates.size() != 0 || busy) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  // One APB transfer to the count register; a read is checked
  task automatic apb_xfer(input bit wr, input logic [APB_DW-1:0] wdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= SEG_COUNT_ADDR;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (wr) begin
      seg_count = wdata[CFG_W-1:0];
    end else if (prdata[CFG_W-1:0] !== seg_count) begin
      $display("%0t: segment count read expected %0d got %0d", $time, seg_count,
               prdata[CFG_W-1:0]);
      mismatches++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Rewrite the count once idle, with junk in the unused data bits
  task automatic set_count(input logic [CFG_W-1:0] value);
    logic [APB_DW-1:0] w;
    w = $urandom;
    w[CFG_W-1:0] = value;
    drain();
    apb_xfer(1'b1, w);
    apb_xfer(1'b0, '0);
  endtask

  // Compare each result with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_xlates.size() == 0) begin
        $display("%0t: unexpected result status %0d entry %0d offset %h", $time,
                 out_status, out_hit_entry, out_hit_offset);
        mismatches++;
      end else begin
        oldest = pending_xlates.pop_front();
        if (out_status !== oldest.status) begin
          $display("%0t: status expected %0d got %0d", $time, oldest.status, out_status);
          mismatches++;
        end
        if (out_hit_entry !== oldest.entry) begin
          $display("%0t: hit_entry expected %0d got %0d", $time, oldest.entry,
                   out_hit_entry);
          mismatches++;
        end
        if (out_hit_offset !== oldest.offset) begin
          $display("%0t: hit_offset expected %h got %h", $time, oldest.offset,
                   out_hit_offset);
          mismatches++;
        end
      end
    end
  end

  initial begin
    logic [CFG_W-1:0] count;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // reset value of the count register
    apb_xfer(1'b0, '0);

    // scripted opening
    gap_pct = 27;
    for (int k = 0; k < $size(SCRIPT); k++) begin
      if (SCRIPT[k].kind == ROW_COUNT) begin
        set_count(SCRIPT[k].count);
      end else begin
        issue(SCRIPT[k].cmd, SCRIPT[k].kind == ROW_CHECKED, SCRIPT[k].want);
      end
    end

    // random traffic: sender idles 27%, then 77%, then never
    for (int blk = 0; blk < 14; blk++) begin
      gap_pct = (blk < 5) ? 27 : (blk < 10) ? 77 : 0;
      case (blk % 5)
        0: count = CFG_W'(MAX_SEGMENTS_DEF);
        1: count = CFG_W'($urandom_range(1, 7));
        2: count = ($urandom_range(1) != 0) ? 4'd15 : CFG_W'($urandom_range(9, 14));
        3: count = 4'd1;
        default: count = 4'd0;
      endcase
      set_count(count);
      repeat ((count == '0) ? 30 : 150) issue(random_cmd(), 1'b0, NO_WANT);
    end

    drain();
    if (mismatches == 0) begin
      $display("segment_table_translate: match");
    end else begin
      $display("segment_table_translate: mismatch");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
rtl/core/stt_pkg.sv
rtl/core/segment_table_translate.sv
test/testbench.sv
